[sv/mfb_pkg.sv]
`default_nettype none
package mfb_pkg;

  localparam int WIDTH_PIXELS = 256;
  localparam int HEIGHT_ROWS  = 64;

  localparam int ROW_BYTES   = (WIDTH_PIXELS + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * HEIGHT_ROWS;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int COL_W       = $clog2(WIDTH_PIXELS);
  localparam int ROW_W       = (HEIGHT_ROWS > 1) ? $clog2(HEIGHT_ROWS) : 1;

  localparam int CHUNK_W     = 7;
  localparam int SRC_W       = 4;
  localparam int FIDX_W      = CHUNK_W + SRC_W;

  localparam logic [7:0] PIX_MSB = 8'h80;
  localparam logic [7:0] NIB_HI  = 8'hf0;
  localparam logic [7:0] NIB_LO  = 8'h0f;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [7:0]        byte_t;

  typedef enum logic [1:0] {
    OP_PLOT  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FETCH = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PEN_SET  = 2'd0,
    PEN_CLR  = 2'd1,
    PEN_INV  = 2'd2,
    PEN_KEEP = 2'd3
  } pen_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    byte_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  typedef struct packed {
    logic vld;
    logic zero;
    logic last;
  } rd_tag_t;

endpackage
`default_nettype wire

[sv/mono_framebuffer_gray_scanout.sv]
// Plot: a read then a write-back of one store byte.
// Fetch: 64 beats at one per cycle while out_ready is high;
// the next item is taken once the 16 store reads have been issued.
// Clear: one write per cycle over the whole store, 2048 bytes at 256 x 64.
// Reset runs the same clearing pass; no item is accepted until it ends.
`default_nettype none
module mono_framebuffer_gray_scanout (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_op,
  input  wire logic signed [15:0]          in_x,
  input  wire logic signed [15:0]          in_y,
  input  wire logic [1:0]                  in_pen,
  input  wire logic [mfb_pkg::CHUNK_W-1:0] in_chunk,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       out_gray_pair,
  output logic                             out_last
);

  mfb_pkg::ram_req_t ram_req;
  mfb_pkg::rd_tag_t  rd_tag;
  mfb_pkg::byte_t    rdata;
  logic              slot_free;

  mfb_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_pen    (in_pen),
    .in_chunk  (in_chunk),
    .slot_free (slot_free),
    .rdata     (rdata),
    .ram_req   (ram_req),
    .rd_tag    (rd_tag)
  );

  mfb_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  mfb_gray u_gray (
    .clk           (clk),
    .rst_n         (rst_n),
    .rd_tag        (rd_tag),
    .rdata         (rdata),
    .slot_free     (slot_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_gray_pair (out_gray_pair),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

[sv/mfb_ram.sv]
`default_nettype none
module mfb_ram (
  input  wire logic              clk,
  input  wire mfb_pkg::ram_req_t req,
  output mfb_pkg::byte_t         rdata
);

  mfb_pkg::byte_t mem [mfb_pkg::STORE_BYTES];
  mfb_pkg::byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[sv/mfb_seq.sv]
`default_nettype none
module mfb_seq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_op,
  input  wire logic signed [15:0]           in_x,
  input  wire logic signed [15:0]           in_y,
  input  wire logic [1:0]                   in_pen,
  input  wire logic [mfb_pkg::CHUNK_W-1:0]  in_chunk,
  input  wire logic                         slot_free,
  input  wire mfb_pkg::byte_t               rdata,
  output mfb_pkg::ram_req_t                 ram_req,
  output mfb_pkg::rd_tag_t                  rd_tag
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PRD   = 5'b00010,
    S_PWR   = 5'b00100,
    S_FETCH = 5'b01000,
    S_CLR   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  mfb_pkg::addr_t              pl_addr_r, pl_addr_nxt;
  mfb_pkg::byte_t              pl_mask_r, pl_mask_nxt;
  logic [1:0]                  pl_pen_r, pl_pen_nxt;
  logic                        pl_en_r, pl_en_nxt;
  logic [mfb_pkg::CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [mfb_pkg::SRC_W-1:0]   src_r, src_nxt;
  mfb_pkg::addr_t              clr_cnt_r, clr_cnt_nxt;

  logic                        in_fire;
  logic                        on_screen;
  logic [mfb_pkg::COL_W-1:0]   xcol;
  logic [mfb_pkg::ROW_W-1:0]   yrow;
  mfb_pkg::addr_t              plot_addr;
  logic [mfb_pkg::FIDX_W-1:0]  fidx;
  logic                        fidx_ok;
  logic                        issue;
  mfb_pkg::byte_t              pl_wdata;

  assign in_ready = (state_r == S_IDLE) || (state_r == S_PWR);
  assign in_fire  = in_valid && in_ready;

  assign on_screen = !in_x[15] && (in_x[14:0] < 15'(mfb_pkg::WIDTH_PIXELS))
                  && !in_y[15] && (in_y[14:0] < 15'(mfb_pkg::HEIGHT_ROWS));
  assign xcol = in_x[mfb_pkg::COL_W-1:0];
  assign yrow = in_y[mfb_pkg::ROW_W-1:0];
  assign plot_addr = mfb_pkg::ADDR_W'(mfb_pkg::ADDR_W'(yrow)
                   * mfb_pkg::ADDR_W'(mfb_pkg::ROW_BYTES))
                   + mfb_pkg::ADDR_W'(xcol[mfb_pkg::COL_W-1:3]);

  assign fidx    = {chunk_r, src_r};
  assign fidx_ok = 32'(fidx) < 32'(mfb_pkg::STORE_BYTES);
  assign issue   = (state_r == S_FETCH) && slot_free;

  always_comb begin
    case (mfb_pkg::pen_t'(pl_pen_r))
      mfb_pkg::PEN_SET: pl_wdata = rdata | pl_mask_r;
      mfb_pkg::PEN_CLR: pl_wdata = rdata & ~pl_mask_r;
      mfb_pkg::PEN_INV: pl_wdata = rdata ^ pl_mask_r;
      default:          pl_wdata = rdata;
    endcase
  end

  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = pl_addr_r;
    ram_req.wdata = pl_wdata;
    ram_req.re    = 1'b0;
    ram_req.raddr = pl_addr_r;
    rd_tag.vld    = issue;
    rd_tag.zero   = !fidx_ok;
    rd_tag.last   = (src_r == {mfb_pkg::SRC_W{1'b1}});
    unique case (state_r)
      S_PRD: ram_req.re = 1'b1;
      S_PWR: ram_req.we = pl_en_r;
      S_FETCH: begin
        ram_req.re    = issue && fidx_ok;
        ram_req.raddr = mfb_pkg::ADDR_W'(fidx);
      end
      S_CLR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_cnt_r;
        ram_req.wdata = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    pl_addr_nxt = pl_addr_r;
    pl_mask_nxt = pl_mask_r;
    pl_pen_nxt  = pl_pen_r;
    pl_en_nxt   = pl_en_r;
    chunk_nxt   = chunk_r;
    src_nxt     = src_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      S_PRD: state_nxt = S_PWR;
      S_FETCH: begin
        if (issue) begin
          src_nxt = src_r + 1'b1;
          if (rd_tag.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == mfb_pkg::ADDR_W'(mfb_pkg::STORE_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // a new item may enter while the previous plot writes back
    if (in_fire) begin
      unique case (mfb_pkg::op_t'(in_op))
        mfb_pkg::OP_PLOT: begin
          state_nxt   = S_PRD;
          pl_addr_nxt = plot_addr;
          pl_mask_nxt = mfb_pkg::PIX_MSB >> xcol[2:0];
          pl_pen_nxt  = in_pen;
          pl_en_nxt   = on_screen && (in_pen != mfb_pkg::PEN_KEEP);
        end
        mfb_pkg::OP_CLEAR: begin
          state_nxt   = S_CLR;
          clr_cnt_nxt = '0;
        end
        mfb_pkg::OP_FETCH: begin
          state_nxt = S_FETCH;
          chunk_nxt = in_chunk;
          src_nxt   = '0;
        end
        mfb_pkg::OP_NOP: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pl_addr_r <= pl_addr_nxt;
    pl_mask_r <= pl_mask_nxt;
    pl_pen_r  <= pl_pen_nxt;
    pl_en_r   <= pl_en_nxt;
    chunk_r   <= chunk_nxt;
    src_r     <= src_nxt;
  end

endmodule
`default_nettype wire

[sv/mfb_gray.sv]
`default_nettype none
module mfb_gray (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mfb_pkg::rd_tag_t rd_tag,
  input  wire mfb_pkg::byte_t   rdata,
  output logic                  slot_free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_gray_pair,
  output logic                  out_last
);

  logic           pend_r, pend_zero_r, pend_last_r;
  logic           nx_vld_r, nx_vld_nxt, nx_last_r;
  mfb_pkg::byte_t nx_byte_r;
  logic           cur_vld_r, cur_vld_nxt, cur_last_r;
  mfb_pkg::byte_t cur_byte_r;
  logic [1:0]     cnt_r;

  logic fire, cur_done, cur_free;

  assign fire      = cur_vld_r && out_ready;
  assign cur_done  = fire && (cnt_r == 2'd3);
  assign cur_free  = !cur_vld_r || cur_done;
  assign slot_free = !nx_vld_r && !pend_r;

  assign out_valid     = cur_vld_r;
  assign out_gray_pair = (cur_byte_r[7] ? mfb_pkg::NIB_HI : 8'h00)
                       | (cur_byte_r[6] ? mfb_pkg::NIB_LO : 8'h00);
  assign out_last      = cur_last_r && (cnt_r == 2'd3);

  always_comb begin
    nx_vld_nxt  = nx_vld_r;
    cur_vld_nxt = cur_vld_r;
    if (cur_free) begin
      cur_vld_nxt = nx_vld_r;
      nx_vld_nxt  = 1'b0;
    end
    // a read is only issued into an empty slot
    if (pend_r) begin
      nx_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      nx_vld_r  <= 1'b0;
      cur_vld_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      pend_r    <= rd_tag.vld;
      nx_vld_r  <= nx_vld_nxt;
      cur_vld_r <= cur_vld_nxt;
      if (cur_free) begin
        cnt_r <= '0;
      end else if (fire) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_zero_r <= rd_tag.zero;
    pend_last_r <= rd_tag.last;
    if (pend_r) begin
      nx_byte_r <= pend_zero_r ? 8'h00 : rdata;
      nx_last_r <= pend_last_r;
    end
    if (cur_free) begin
      cur_byte_r <= nx_byte_r;
      cur_last_r <= nx_last_r;
    end else if (fire) begin
      // advance to the next pixel pair
      cur_byte_r <= {cur_byte_r[5:0], 2'b00};
    end
  end

endmodule
`default_nettype wire

[sv/mfb_chk.sv]
`default_nettype none
module mfb_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [1:0]                  in_op,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [7:0]                  out_gray_pair,
  input wire logic                        out_last
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_gray_pair) && $stable(out_last))
    else $error("stalled result beat changed");

  a_nibbles: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gray_pair[7:4] == 4'h0 || out_gray_pair[7:4] == 4'hf)
               && (out_gray_pair[3:0] == 4'h0 || out_gray_pair[3:0] == 4'hf))
    else $error("gray nibble is neither black nor white");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("item taken or beat shown during clearing pass");

  a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == mfb_pkg::OP_FETCH |=> !in_ready)
    else $error("input taken right after a fetch");

endmodule

bind mono_framebuffer_gray_scanout mfb_chk u_mfb_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_gray_pair (out_gray_pair),
  .out_last      (out_last)
);
`default_nettype wire
